// ===== sv/gob_pkg.sv =====
// Shared types and constants of the gradient orientation binner.
`default_nettype none

package gob_pkg;

  localparam int unsigned BIN_W = 4;
  localparam int unsigned MAG_W = 13;

  typedef logic [BIN_W-1:0] bin_t;
  typedef logic [MAG_W-1:0] mag_t;

  // Largest magnitude the output word can carry; wider results saturate here.
  localparam mag_t MAG_MAX = 13'd8191;

  // Register stages from the orientation unit's inputs to its bin output.
  localparam int unsigned ORI_LAT = 6;

endpackage

`default_nettype wire

// ===== sv/gob_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
`default_nettype none

module gob_isqrt #(
  parameter int unsigned RAD_W = 17
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [RAD_W-1:0]             rad_i,
  output logic                              valid_o,
  output logic [(RAD_W+1)/2-1:0]            root_o
);

  localparam int unsigned NR = (RAD_W + 1) / 2;
  localparam int unsigned PW = 2 * NR;
  localparam int unsigned RW = NR + 3;

  logic [RW-1:0] rem_q  [NR];
  logic [NR-1:0] root_q [NR];
  logic [PW-1:0] rest_q [NR];
  logic          vld_q  [NR];

  for (genvar k = 0; k < NR; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [NR-1:0] root_in;
    logic [PW-1:0] rest_in;
    logic          vld_in;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_d;
    logic [NR-1:0] root_d;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = PW'(rad_i);
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rest_in = rest_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next bit pair and try to subtract 4*root + 1.
    assign rem_sh = {rem_in[RW-3:0], rest_in[PW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_comb begin
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[NR-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[NR-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      rest_q[k] <= {rest_in[PW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[NR-1];
  assign root_o  = root_q[NR-1];

endmodule

`default_nettype wire

// ===== sv/gob_orient.sv =====
// Orientation bin pipeline: exact sector test on the cube of the gradient.
`default_nettype none

module gob_orient #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic signed [PIXEL_BITS:0]    gx_i,
  input  wire logic signed [PIXEL_BITS:0]    gy_i,
  input  wire logic [2*PIXEL_BITS-1:0]       gx2_i,
  input  wire logic [2*PIXEL_BITS-1:0]       gy2_i,
  output gob_pkg::bin_t                      bin_o
);

  localparam int unsigned P  = PIXEL_BITS;
  localparam int unsigned GW = P + 1;
  localparam int unsigned TW = 2 * P + 3;
  localparam int unsigned PW = GW + TW;
  localparam int unsigned MW = 3 * P + 2;
  localparam int unsigned LH = (MW + 1) / 2;
  localparam int unsigned HH = MW - LH;
  localparam int unsigned QW = 2 * MW;

  // Sectors of the tripled angle, named by their start in degrees.
  localparam logic [2:0] SEC_30  = 3'd0;
  localparam logic [2:0] SEC_90  = 3'd1;
  localparam logic [2:0] SEC_150 = 3'd2;
  localparam logic [2:0] SEC_210 = 3'd3;
  localparam logic [2:0] SEC_270 = 3'd4;
  localparam logic [2:0] SEC_330 = 3'd5;

  localparam gob_pkg::bin_t BIN_ZERO_GRAD = 4'd8;
  localparam gob_pkg::bin_t BIN_WRAP      = 4'd8;
  localparam gob_pkg::bin_t BIN_MID_WRAP  = 4'd5;
  localparam gob_pkg::bin_t BIN_SHIFT     = 4'd6;

  typedef struct packed {
    logic near;
    logic zero;
    logic gxpos;
  } dir_t;

  typedef struct packed {
    logic apos;
    logic aneg;
    logic cpos;
    logic czero;
  } sgn_t;

  // Stage 1
  logic signed [GW-1:0] gx1_q, gy1_q;
  logic signed [TW-1:0] t1_q, t2_q;
  dir_t                 dir1_q, dir1_d;
  logic signed [TW-1:0] t1_d, t2_d;

  // Stage 2
  logic signed [PW-1:0] a_q, c_q;
  dir_t                 dir2_q;

  // Stage 3
  logic [MW-1:0] amag_q, cmag_q;
  sgn_t          sgn3_q, sgn3_d;
  dir_t          dir3_q;

  // Stage 4
  logic [2*HH-1:0]  ahh_q, chh_q;
  logic [HH+LH-1:0] ahl_q, chl_q;
  logic [2*LH-1:0]  all_q, cll_q;
  sgn_t             sgn4_q;
  dir_t             dir4_q;

  // Stage 5
  logic [QW-1:0] a2_q, c2_q;
  sgn_t          sgn5_q;
  dir_t          dir5_q;

  // Stage 6
  gob_pkg::bin_t bin_q, bin_d;
  logic [QW+1:0] c3;
  logic          gt;
  logic [2:0]    sec;

  always_comb begin
    t1_d = $signed({3'b000, gx2_i}) -
           ($signed({2'b00, gy2_i, 1'b0}) + $signed({3'b000, gy2_i}));
    t2_d = ($signed({2'b00, gx2_i, 1'b0}) + $signed({3'b000, gx2_i})) -
           $signed({3'b000, gy2_i});
    dir1_d.near  = ({2'b00, gy2_i} < ({1'b0, gx2_i, 1'b0} + {2'b00, gx2_i}));
    dir1_d.zero  = (gx_i == '0) && (gy_i == '0);
    dir1_d.gxpos = !gx_i[GW-1] && (gx_i != '0);
  end

  always_comb begin
    sgn3_d.aneg  = a_q[PW-1];
    sgn3_d.apos  = !a_q[PW-1] && (a_q != '0);
    sgn3_d.cpos  = !c_q[PW-1] && (c_q != '0);
    sgn3_d.czero = (c_q == '0);
  end

  always_ff @(posedge clk_i) begin
    gx1_q  <= gx_i;
    gy1_q  <= gy_i;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    dir1_q <= dir1_d;

    // a = gx^3 - 3 gx gy^2 and c = 3 gx^2 gy - gy^3 are the parts of (gx + i gy)^3.
    a_q    <= gx1_q * t1_q;
    c_q    <= gy1_q * t2_q;
    dir2_q <= dir1_q;

    amag_q <= a_q[PW-1] ? MW'(-a_q) : MW'(a_q);
    cmag_q <= c_q[PW-1] ? MW'(-c_q) : MW'(c_q);
    sgn3_q <= sgn3_d;
    dir3_q <= dir2_q;

    // Squares are split into half-width partial products.
    ahh_q  <= amag_q[MW-1 -: HH] * amag_q[MW-1 -: HH];
    ahl_q  <= amag_q[MW-1 -: HH] * amag_q[LH-1:0];
    all_q  <= amag_q[LH-1:0] * amag_q[LH-1:0];
    chh_q  <= cmag_q[MW-1 -: HH] * cmag_q[MW-1 -: HH];
    chl_q  <= cmag_q[MW-1 -: HH] * cmag_q[LH-1:0];
    cll_q  <= cmag_q[LH-1:0] * cmag_q[LH-1:0];
    sgn4_q <= sgn3_q;
    dir4_q <= dir3_q;

    a2_q   <= (QW'(ahh_q) << (2 * LH)) + (QW'(ahl_q) << (LH + 1)) + QW'(all_q);
    c2_q   <= (QW'(chh_q) << (2 * LH)) + (QW'(chl_q) << (LH + 1)) + QW'(cll_q);
    sgn5_q <= sgn4_q;
    dir5_q <= dir4_q;

    bin_q  <= bin_d;
  end

  // The tripled angle crosses a sector edge where 3 c^2 equals a^2.
  assign c3 = {1'b0, c2_q, 1'b0} + {2'b00, c2_q};
  assign gt = c3 > {2'b00, a2_q};

  always_comb begin
    if (sgn5_q.czero) begin
      sec = sgn5_q.apos ? SEC_330 : SEC_150;
    end else if (sgn5_q.cpos) begin
      if (sgn5_q.apos) begin
        sec = gt ? SEC_30 : SEC_330;
      end else begin
        sec = gt ? SEC_90 : SEC_150;
      end
    end else begin
      if (sgn5_q.aneg) begin
        sec = gt ? SEC_210 : SEC_150;
      end else begin
        sec = gt ? SEC_270 : SEC_330;
      end
    end

    // Directions below 60 or from 120 degrees reuse the sectors shifted by a third turn.
    if (dir5_q.zero) begin
      bin_d = BIN_ZERO_GRAD;
    end else if (dir5_q.near) begin
      if (dir5_q.gxpos) begin
        bin_d = (sec == SEC_330) ? BIN_WRAP : gob_pkg::bin_t'(sec);
      end else begin
        bin_d = (sec == SEC_330) ? BIN_MID_WRAP : gob_pkg::bin_t'(sec) + BIN_SHIFT;
      end
    end else begin
      bin_d = gob_pkg::bin_t'(sec);
    end
  end

  assign bin_o = bin_q;

endmodule

`default_nettype wire

// ===== sv/gradient_orientation_binner.sv =====
// Top level of the gradient orientation binner: HOG gradient magnitude and 9-bin orientation.
//
//   channel   ports                                          handshake
//   -------   --------------------------------------------   -----------------------------
//   input     pix_left_i, pix_right_i, pix_up_i, pix_down_i   start_i, taken when !busy_o
//   result    orient_bin_o, grad_mag_o                        done_o, one cycle per word
//
// One input word is taken in every cycle; busy_o never rises because nothing in the
// pipeline ever waits. The depth of the pipeline is set by the square root, which
// resolves one result bit per register stage. The receiver cannot stall, so the pipeline
// simply advances every cycle. Reset clears the valid bits only; data registers are free.
`default_nettype none

module gradient_orientation_binner #(
  parameter int unsigned PIXEL_BITS    = 8,
  parameter int unsigned MAG_FRAC_BITS = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [PIXEL_BITS-1:0] pix_left_i,
  input  wire logic [PIXEL_BITS-1:0] pix_right_i,
  input  wire logic [PIXEL_BITS-1:0] pix_up_i,
  input  wire logic [PIXEL_BITS-1:0] pix_down_i,
  output logic                       done_o,
  output gob_pkg::bin_t              orient_bin_o,
  output gob_pkg::mag_t              grad_mag_o
);

  localparam int unsigned P     = PIXEL_BITS;
  localparam int unsigned GW    = P + 1;
  localparam int unsigned SW    = 2 * P;
  localparam int unsigned RAD_W = 2 * P + 1 + 2 * MAG_FRAC_BITS;
  localparam int unsigned NR    = (RAD_W + 1) / 2;
  localparam int unsigned CW    = (NR > gob_pkg::MAG_W) ? NR : gob_pkg::MAG_W;
  // The bin is ready after stage 2 plus the orientation unit; the root after stage 3
  // plus the root stages. The bin waits in a short delay line for the root.
  localparam int unsigned BD    = NR + 3 - 2 - gob_pkg::ORI_LAT;

  // Stage 1: central differences.
  logic signed [GW-1:0] gx_q, gy_q, gx_d, gy_d;
  logic                 v1_q;

  // Stage 2: squares and the fold into the upper half plane.
  logic signed [2*GW-1:0] gxsq, gysq;
  logic                   flip;
  logic signed [GW-1:0]   gxf_q, gyf_q;
  logic [SW-1:0]          gx2_q, gy2_q;
  logic                   v2_q;

  // Stage 3: sum of squares that feeds the root.
  logic [SW:0] sum_q;
  logic        v3_q;

  logic [RAD_W-1:0] rad;
  logic             root_vld;
  logic [NR-1:0]    root;

  gob_pkg::bin_t bin;
  gob_pkg::bin_t bin_dly_q [BD];

  gob_pkg::mag_t mag_d, mag_q;
  gob_pkg::bin_t bin_out_q;
  logic          done_q;

  assign busy_o = 1'b0;

  assign gx_d = $signed({1'b0, pix_right_i}) - $signed({1'b0, pix_left_i});
  assign gy_d = $signed({1'b0, pix_down_i}) - $signed({1'b0, pix_up_i});

  assign gxsq = gx_q * gx_q;
  assign gysq = gy_q * gy_q;

  // Opposite directions share a bin, so the vector is turned into gy >= 0, and a
  // purely horizontal one into gx > 0.
  assign flip = gy_q[GW-1] || ((gy_q == '0) && gx_q[GW-1]);

  always_ff @(posedge clk_i) begin
    gx_q  <= gx_d;
    gy_q  <= gy_d;
    gxf_q <= flip ? -gx_q : gx_q;
    gyf_q <= flip ? -gy_q : gy_q;
    gx2_q <= gxsq[SW-1:0];
    gy2_q <= gysq[SW-1:0];
    sum_q <= {1'b0, gx2_q} + {1'b0, gy2_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  gob_orient #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_orient (
    .clk_i (clk_i),
    .gx_i  (gxf_q),
    .gy_i  (gyf_q),
    .gx2_i (gx2_q),
    .gy2_i (gy2_q),
    .bin_o (bin)
  );

  // The magnitude carries MAG_FRAC_BITS fraction bits: the root of sum * 4^frac.
  assign rad = RAD_W'(sum_q) << (2 * MAG_FRAC_BITS);

  gob_isqrt #(
    .RAD_W(RAD_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (rad),
    .valid_o (root_vld),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    bin_dly_q[0] <= bin;
    for (int i = 1; i < BD; i++) begin
      bin_dly_q[i] <= bin_dly_q[i-1];
    end
  end

  // Magnitudes that do not fit the output word are clamped to its largest value.
  assign mag_d = (CW'(root) > CW'(gob_pkg::MAG_MAX)) ? gob_pkg::MAG_MAX
                                                      : gob_pkg::mag_t'(root);

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bin_out_q <= bin_dly_q[BD-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= root_vld;
    end
  end

  assign done_o       = done_q;
  assign orient_bin_o = bin_out_q;
  assign grad_mag_o   = mag_q;

endmodule

`default_nettype wire
